### hw/rtl/tsc_pkg.sv
// Shared types, constants and register map of the touch sample calibrator.
package tsc_pkg;

  localparam int unsigned ADC_BITS_DEF  = 10;
  localparam int unsigned NUM_FIELDS_IN = 7;

  localparam int unsigned COEF_W  = 32;
  localparam int unsigned DIVR_W  = 31;
  localparam int unsigned BASE_W  = 16;
  localparam int unsigned OUT_W   = 16;
  localparam int unsigned LEVEL_W = 10;
  localparam int unsigned AVG_W   = 18;
  localparam int unsigned QUOT_W  = 17;

  localparam int unsigned APB_DATA_W  = 64;
  localparam int unsigned APB_ADDR_W  = 6;
  localparam int unsigned REG_SEL_LSB = 3;
  localparam int unsigned REG_SEL_W   = APB_ADDR_W - REG_SEL_LSB;

  localparam int unsigned OUT_FIELDS_W = 2 * OUT_W + 1 + LEVEL_W + OUT_W + LEVEL_W + 2 * AVG_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  localparam int unsigned PLANE_SHIFT = 16;
  localparam int unsigned PLANE_ROUND = 1 << (PLANE_SHIFT - 1);
  localparam int unsigned PLANE_MASK  = (1 << PLANE_SHIFT) - 1;
  localparam int unsigned W_OLD       = 230;
  localparam int unsigned W_NEW       = 26 * 256;
  localparam int unsigned AVG_SHIFT   = 8;
  localparam int unsigned AVG_ROUND   = 1 << (AVG_SHIFT - 1);

  localparam logic [COEF_W*2-1:0] RST_CAL_X_GAINS = 64'h0000_0000_0001_0000;
  localparam logic [COEF_W*2-1:0] RST_CAL_Y_GAINS = 64'h0001_0000_0000_0000;
  localparam logic [DIVR_W-1:0]   RST_CAL_DIVISOR = 31'd65536;

  localparam logic signed [OUT_W-1:0] SAT_MAX = 16'sh7fff;
  localparam logic signed [OUT_W-1:0] SAT_MIN = 16'sh8000;
  localparam logic [QUOT_W-1:0]       Q_POS_LIM = 17'd32767;
  localparam logic [QUOT_W-1:0]       Q_NEG_LIM = 17'd32768;

  typedef enum logic [REG_SEL_W-1:0] {
    REG_CAL_X_GAINS  = 3'd0,
    REG_CAL_X_OFFSET = 3'd1,
    REG_CAL_Y_GAINS  = 3'd2,
    REG_CAL_Y_OFFSET = 3'd3,
    REG_CAL_DIVISOR  = 3'd4,
    REG_PLANE_GAINS  = 3'd5,
    REG_PLANE_OFFSET = 3'd6,
    REG_TOUCH_BASE   = 3'd7
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ACC,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_PLANE,
    ST_SMOOTH,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    TERM_X,
    TERM_Y,
    TERM_PLANE
  } term_e;

  typedef struct packed {
    logic [COEF_W*2-1:0]        cal_x_gains;
    logic signed [COEF_W-1:0]   cal_x_offset;
    logic [COEF_W*2-1:0]        cal_y_gains;
    logic signed [COEF_W-1:0]   cal_y_offset;
    logic [DIVR_W-1:0]          cal_divisor;
    logic [COEF_W*2-1:0]        plane_gains;
    logic signed [COEF_W-1:0]   plane_offset;
    logic signed [BASE_W-1:0]   touch_base;
  } cfg_t;

  typedef struct packed {
    logic mul;
    logic init;
    logic accum;
  } mac_ctl_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic signed [OUT_W-1:0] quot;
  } div_rsp_t;

endpackage

### hw/rtl/tsc_cfg_regs.sv
// APB register file holding the calibration and threshold-plane settings.
module tsc_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tsc_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [tsc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [tsc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output tsc_pkg::cfg_t                    cfg_o
);
  import tsc_pkg::*;

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[APB_ADDR_W-1:REG_SEL_LSB]);
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cal_x_gains  <= RST_CAL_X_GAINS;
      cfg_q.cal_x_offset <= '0;
      cfg_q.cal_y_gains  <= RST_CAL_Y_GAINS;
      cfg_q.cal_y_offset <= '0;
      cfg_q.cal_divisor  <= RST_CAL_DIVISOR;
      cfg_q.plane_gains  <= '0;
      cfg_q.plane_offset <= '0;
      cfg_q.touch_base   <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_CAL_X_GAINS:  cfg_q.cal_x_gains  <= pwdata;
        REG_CAL_X_OFFSET: cfg_q.cal_x_offset <= pwdata[COEF_W-1:0];
        REG_CAL_Y_GAINS:  cfg_q.cal_y_gains  <= pwdata;
        REG_CAL_Y_OFFSET: cfg_q.cal_y_offset <= pwdata[COEF_W-1:0];
        REG_CAL_DIVISOR:  cfg_q.cal_divisor  <= pwdata[DIVR_W-1:0];
        REG_PLANE_GAINS:  cfg_q.plane_gains  <= pwdata;
        REG_PLANE_OFFSET: cfg_q.plane_offset <= pwdata[COEF_W-1:0];
        REG_TOUCH_BASE:   cfg_q.touch_base   <= pwdata[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CAL_X_GAINS:  prdata = cfg_q.cal_x_gains;
      REG_CAL_X_OFFSET: prdata = {32'b0, cfg_q.cal_x_offset};
      REG_CAL_Y_GAINS:  prdata = cfg_q.cal_y_gains;
      REG_CAL_Y_OFFSET: prdata = {32'b0, cfg_q.cal_y_offset};
      REG_CAL_DIVISOR:  prdata = {33'b0, cfg_q.cal_divisor};
      REG_PLANE_GAINS:  prdata = cfg_q.plane_gains;
      REG_PLANE_OFFSET: prdata = {32'b0, cfg_q.plane_offset};
      REG_TOUCH_BASE:   prdata = {48'b0, cfg_q.touch_base};
      default:          prdata = '0;
    endcase
  end

endmodule

### hw/rtl/tsc_mac.sv
// Shared multiply-accumulate unit: registered product, then accumulator.
module tsc_mac #(
  parameter int unsigned ADC_BITS = tsc_pkg::ADC_BITS_DEF,
  parameter int unsigned NUM_W    = ADC_BITS + 34
) (
  input  logic                                clk_i,
  input  tsc_pkg::mac_ctl_t                   ctl_i,
  input  logic signed [tsc_pkg::COEF_W-1:0]   coef_i,
  input  logic signed [ADC_BITS:0]            opnd_i,
  input  logic signed [NUM_W-1:0]             addend_i,
  output logic signed [NUM_W-1:0]             acc_o
);
  import tsc_pkg::*;

  localparam int unsigned PROD_W = COEF_W + ADC_BITS + 1;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [NUM_W-1:0]  acc_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul) begin
      prod_q <= PROD_W'(coef_i) * PROD_W'(opnd_i);
    end
    if (ctl_i.init) begin
      acc_q <= addend_i + NUM_W'(prod_q);
    end else if (ctl_i.accum) begin
      acc_q <= acc_q + NUM_W'(prod_q);
    end
  end

  assign acc_o = acc_q;

endmodule

### hw/rtl/tsc_divider.sv
// Restoring divider, one quotient bit per cycle, signed result saturated to 16 bits.
module tsc_divider #(
  parameter int unsigned NUM_W = tsc_pkg::ADC_BITS_DEF + 34
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [NUM_W-1:0]           num_i,
  input  logic [tsc_pkg::DIVR_W-1:0]        divisor_i,
  output tsc_pkg::div_rsp_t                 rsp_o
);
  import tsc_pkg::*;

  localparam int unsigned DSH_W = DIVR_W + QUOT_W;
  localparam int unsigned CMP_W = (NUM_W > DSH_W) ? NUM_W : DSH_W;
  localparam int unsigned CNT_W = $clog2(QUOT_W + 1);

  logic                busy_q;
  logic                done_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                neg_q;
  logic                ovf_q;
  logic [NUM_W-1:0]    rem_q;
  logic [DSH_W-1:0]    dsh_q;
  logic [QUOT_W-1:0]   q_q;

  logic [NUM_W-1:0]    mag;
  logic [CMP_W-1:0]    rem_ext;
  logic [CMP_W-1:0]    dsh_ext;
  logic [CMP_W-1:0]    diff;
  logic                ge;
  logic                sat_pos;
  logic                sat_neg;

  assign mag     = num_i[NUM_W-1] ? NUM_W'(~num_i + NUM_W'(1)) : NUM_W'(num_i);
  assign rem_ext = CMP_W'(rem_q);
  assign dsh_ext = CMP_W'(dsh_q);
  assign ge      = rem_ext >= dsh_ext;
  assign diff    = rem_ext - dsh_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(QUOT_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // first step only checks for a quotient beyond 17 bits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[NUM_W-1];
      ovf_q <= 1'b0;
      rem_q <= mag;
      dsh_q <= {divisor_i, QUOT_W'(0)};
      q_q   <= '0;
    end else if (busy_q) begin
      dsh_q <= dsh_q >> 1;
      if (cnt_q == CNT_W'(QUOT_W)) begin
        ovf_q <= ge;
      end else begin
        q_q <= {q_q[QUOT_W-2:0], ge};
        if (ge) begin
          rem_q <= NUM_W'(diff);
        end
      end
    end
  end

  assign sat_pos = !neg_q && (ovf_q || (q_q > Q_POS_LIM));
  assign sat_neg = neg_q && (ovf_q || (q_q > Q_NEG_LIM));

  always_comb begin
    rsp_o.busy = busy_q;
    rsp_o.done = done_q;
    if (sat_pos) begin
      rsp_o.quot = SAT_MAX;
    end else if (sat_neg) begin
      rsp_o.quot = SAT_MIN;
    end else if (neg_q) begin
      rsp_o.quot = OUT_W'(~q_q[OUT_W-1:0] + OUT_W'(1));
    end else begin
      rsp_o.quot = q_q[OUT_W-1:0];
    end
  end

endmodule

### hw/rtl/touch_sample_calibrator.sv
// Top level of the touch sample calibrator: sequencer, sample capture and result stage.
// Each sample runs the X, Y and plane terms, then smoothing, before output tvalid; the next sample waits for that.
// The two calibration divisions run one after the other on one 18-step restoring divider,
// and all six coefficient products go through one shared multiplier.
// Input tready is high only while the sequencer is idle; the output register holds one result.
// Reset (async, active low) restores default calibration and clears both running averages.
module touch_sample_calibrator #(
  parameter  int unsigned ADC_BITS   = tsc_pkg::ADC_BITS_DEF,
  localparam int unsigned IN_TDATA_W = ((tsc_pkg::NUM_FIELDS_IN * ADC_BITS + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // x_raw_first, x_raw_second, y_raw_first, y_raw_second,
  // level_raw_first, level_raw_second, pressure_raw (ADC_BITS each, zero pad)
  input  logic [IN_TDATA_W-1:0]             s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // screen_x, screen_y, touch_down, level_mean, level_threshold,
  // level_spread, level_average, pressure_average (zero pad)
  output logic [tsc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tsc_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [tsc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [tsc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import tsc_pkg::*;

  localparam int unsigned NUM_W  = ADC_BITS + 34;
  localparam int unsigned PQ_W   = NUM_W - PLANE_SHIFT;
  localparam int unsigned THR_W  = PQ_W + 1;
  localparam int unsigned SM_W   = ((ADC_BITS + 13 > 26) ? ADC_BITS + 13 : 26) + 1;
  localparam int unsigned SH_W   = SM_W - AVG_SHIFT;

  cfg_t      cfg;
  mac_ctl_t  mac_ctl;
  div_rsp_t  div_rsp;
  state_e    state_q, state_d;
  term_e     term_q;

  logic in_fire, cap_en, div_start, res_load, plane_en, smooth_en, out_load;

  logic [ADC_BITS-1:0] x1, x2, y1, y2, l1, l2, pr;
  logic [ADC_BITS-1:0] wx_q, wy_q, lmean_q, spread_q, pres_q;

  logic [COEF_W*2-1:0]       gains_sel;
  logic signed [COEF_W-1:0]  off_sel;
  logic signed [COEF_W-1:0]  coef;
  logic signed [NUM_W-1:0]   addend;
  logic signed [NUM_W-1:0]   round_add;
  logic signed [NUM_W-1:0]   acc;
  logic signed [NUM_W-1:0]   biased;

  logic signed [OUT_W-1:0]   sx_q, sy_q, thr_sat_q, thr_sat;
  logic signed [PQ_W-1:0]    pdiv_q;
  logic signed [THR_W-1:0]   thr;
  logic                      down_q;
  logic [AVG_W-1:0]          lvl_avg_q, prs_avg_q, lvl_new, prs_new;
  logic [SM_W-1:0]           lvl_sum, prs_sum;
  logic [SH_W-1:0]           lvl_sh, prs_sh;

  logic                      m_valid_q;
  logic [OUT_TDATA_W-1:0]    m_data_q;

  tsc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tsc_mac #(
    .ADC_BITS (ADC_BITS),
    .NUM_W    (NUM_W)
  ) u_mac (
    .clk_i    (clk_i),
    .ctl_i    (mac_ctl),
    .coef_i   (coef),
    .opnd_i   (state_q == ST_MUL_HI ? $signed({1'b0, wy_q}) : $signed({1'b0, wx_q})),
    .addend_i (addend),
    .acc_o    (acc)
  );

  tsc_divider #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .num_i     (acc),
    .divisor_i (cfg.cal_divisor),
    .rsp_o     (div_rsp)
  );

  // input unpack and pair reduction
  assign x1 = s_axis_tdata_i[0*ADC_BITS +: ADC_BITS];
  assign x2 = s_axis_tdata_i[1*ADC_BITS +: ADC_BITS];
  assign y1 = s_axis_tdata_i[2*ADC_BITS +: ADC_BITS];
  assign y2 = s_axis_tdata_i[3*ADC_BITS +: ADC_BITS];
  assign l1 = s_axis_tdata_i[4*ADC_BITS +: ADC_BITS];
  assign l2 = s_axis_tdata_i[5*ADC_BITS +: ADC_BITS];
  assign pr = s_axis_tdata_i[6*ADC_BITS +: ADC_BITS];

  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i) begin
    if (cap_en) begin
      wx_q     <= ADC_BITS'(({1'b0, x1} + {1'b0, x2}) >> 1);
      wy_q     <= ADC_BITS'(({1'b0, y1} + {1'b0, y2}) >> 1);
      lmean_q  <= ADC_BITS'(({1'b0, l1} + {1'b0, l2}) >> 1);
      spread_q <= (l1 >= l2) ? (l1 - l2) : (l2 - l1);
      pres_q   <= pr;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (in_fire) state_d = ST_MUL_LO;
      ST_MUL_LO:    state_d = ST_MUL_HI;
      ST_MUL_HI:    state_d = ST_ACC;
      ST_ACC:       state_d = (term_q == TERM_PLANE) ? ST_PLANE : ST_DIV_START;
      ST_DIV_START: state_d = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (div_rsp.done) state_d = ST_MUL_LO;
      ST_PLANE:     state_d = ST_SMOOTH;
      ST_SMOOTH:    state_d = ST_OUT;
      ST_OUT:       if (!m_valid_q || m_axis_tready_i) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    cap_en          = 1'b0;
    mac_ctl         = '0;
    div_start       = 1'b0;
    res_load        = 1'b0;
    plane_en        = 1'b0;
    smooth_en       = 1'b0;
    out_load        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        cap_en          = s_axis_tvalid_i;
      end
      ST_MUL_LO:    mac_ctl.mul = 1'b1;
      ST_MUL_HI: begin
        mac_ctl.mul  = 1'b1;
        mac_ctl.init = 1'b1;
      end
      ST_ACC:       mac_ctl.accum = 1'b1;
      ST_DIV_START: div_start = 1'b1;
      ST_DIV_WAIT:  res_load = div_rsp.done;
      ST_PLANE:     plane_en = 1'b1;
      ST_SMOOTH:    smooth_en = 1'b1;
      ST_OUT:       out_load = !m_valid_q || m_axis_tready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      term_q  <= TERM_X;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        term_q <= TERM_X;
      end else if (res_load) begin
        term_q <= (term_q == TERM_X) ? TERM_Y : TERM_PLANE;
      end
    end
  end

  // coefficient select for the shared multiplier
  always_comb begin
    case (term_q)
      TERM_X: begin
        gains_sel = cfg.cal_x_gains;
        off_sel   = cfg.cal_x_offset;
      end
      TERM_Y: begin
        gains_sel = cfg.cal_y_gains;
        off_sel   = cfg.cal_y_offset;
      end
      TERM_PLANE: begin
        gains_sel = cfg.plane_gains;
        off_sel   = cfg.plane_offset;
      end
      default: begin
        gains_sel = '0;
        off_sel   = '0;
      end
    endcase
  end

  assign coef      = (state_q == ST_MUL_HI) ? $signed(gains_sel[2*COEF_W-1:COEF_W])
                                            : $signed(gains_sel[COEF_W-1:0]);
  assign round_add = (term_q == TERM_PLANE) ? NUM_W'(PLANE_ROUND) : '0;
  assign addend    = NUM_W'(off_sel) + round_add;

  // plane quotient: the rounding term comes in as the MAC addend, then the shift truncates toward zero
  assign biased = acc + (acc[NUM_W-1] ? NUM_W'(PLANE_MASK) : NUM_W'(0));

  always_ff @(posedge clk_i) begin
    if (res_load && term_q == TERM_X) begin
      sx_q <= div_rsp.quot;
    end
    if (res_load && term_q == TERM_Y) begin
      sy_q <= div_rsp.quot;
    end
    if (plane_en) begin
      pdiv_q <= PQ_W'(biased >>> PLANE_SHIFT);
    end
    if (smooth_en) begin
      thr_sat_q <= thr_sat;
      down_q    <= $signed(THR_W'({1'b0, lmean_q})) < thr;
    end
  end

  assign thr = THR_W'(cfg.touch_base) + THR_W'(pdiv_q);

  always_comb begin
    if (thr > THR_W'(SAT_MAX)) begin
      thr_sat = SAT_MAX;
    end else if (thr < THR_W'(SAT_MIN)) begin
      thr_sat = SAT_MIN;
    end else begin
      thr_sat = thr[OUT_W-1:0];
    end
  end

  // running averages in Q10.8
  assign lvl_sum = SM_W'(lvl_avg_q) * SM_W'(W_OLD) + SM_W'(lmean_q) * SM_W'(W_NEW)
                 + SM_W'(AVG_ROUND);
  assign prs_sum = SM_W'(prs_avg_q) * SM_W'(W_OLD) + SM_W'(pres_q) * SM_W'(W_NEW)
                 + SM_W'(AVG_ROUND);
  assign lvl_sh  = SH_W'(lvl_sum >> AVG_SHIFT);
  assign prs_sh  = SH_W'(prs_sum >> AVG_SHIFT);
  assign lvl_new = (|lvl_sh[SH_W-1:AVG_W]) ? '1 : lvl_sh[AVG_W-1:0];
  assign prs_new = (|prs_sh[SH_W-1:AVG_W]) ? '1 : prs_sh[AVG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_avg_q <= '0;
      prs_avg_q <= '0;
    end else if (smooth_en) begin
      lvl_avg_q <= lvl_new;
      prs_avg_q <= prs_new;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {OUT_PAD_W'(0), prs_avg_q, lvl_avg_q, LEVEL_W'(spread_q), thr_sat_q,
                   LEVEL_W'(lmean_q), down_q, sy_q, sx_q};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == ST_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  a_no_plane_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV_START |-> term_q != TERM_PLANE)
    else $error("plane term sent to divider");

  a_accept_starts_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_MUL_LO && term_q == TERM_X)
    else $error("transfer did not start the X term");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> m_axis_tvalid_o && state_q == ST_IDLE)
    else $error("result load did not present a transfer");

endmodule
